@@ hdl/tsop_pkg.sv @@
// Shared types and constants for the TCP SYN option parser.
// No dependencies; every other file of the block but tsop_if uses this package.
`timescale 1ns / 1ps
`default_nettype none

package tsop_pkg;

  // Result status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TOO_LONG = 3'd1;
  localparam logic [2:0] ST_TRUNC    = 3'd2;
  localparam logic [2:0] ST_BAD_LEN  = 3'd3;
  localparam logic [2:0] ST_DUP      = 3'd4;
  localparam logic [2:0] ST_BAD_MSS  = 3'd5;

  // The byte counter saturates at its all-ones value.
  localparam int unsigned COUNT_W = 6;

  // One option-area byte as it travels inside the block.
  typedef struct packed {
    logic [7:0] opt_byte;
    logic       last_byte;
    logic       empty_area;
  } item_t;

  // One parse result.
  typedef struct packed {
    logic [2:0]  status;
    logic        mss_found;
    logic [15:0] seg_size;
    logic        scale_found;
    logic [3:0]  scale_shift;
    logic        sack_ok;
    logic        stamp_found;
    logic [31:0] stamp_value;
    logic [31:0] stamp_echo;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/tsop_if.sv @@
// Valid/ready channel interfaces for the option byte input and the result output.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface tsop_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opt_byte;
  logic       last_byte;
  logic       empty_area;

  modport source (output valid, output opt_byte, output last_byte, output empty_area,
                  input ready);
  modport sink (input valid, input opt_byte, input last_byte, input empty_area,
                output ready);
endinterface

interface tsop_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        mss_found;
  logic [15:0] seg_size;
  logic        scale_found;
  logic [3:0]  scale_shift;
  logic        sack_ok;
  logic        stamp_found;
  logic [31:0] stamp_value;
  logic [31:0] stamp_echo;

  modport source (output valid, output status, output mss_found, output seg_size,
                  output scale_found, output scale_shift, output sack_ok,
                  output stamp_found, output stamp_value, output stamp_echo,
                  input ready);
  modport sink (input valid, input status, input mss_found, input seg_size,
                input scale_found, input scale_shift, input sack_ok,
                input stamp_found, input stamp_value, input stamp_echo,
                output ready);
endinterface

`default_nettype wire

@@ hdl/tcp_syn_option_parser_top.sv @@
// Top level of the TCP SYN option parser.
// Depends on tsop_pkg, tsop_if, tsop_in_reg, tsop_parse and tsop_out_reg.
//
// Usage: the option area of one SYN segment enters on opts, one byte per
// request, with last_byte set on its final byte. A request with empty_area
// set carries no byte and closes an empty area with the default result.
// Exactly one result leaves on result for each area, on its last byte.
// Path: an accepted byte waits in the input register, is parsed from there as
// it leaves, and its result, if any, is captured in the result register.
// Throughput: one byte per cycle outside the stalls below; the per-byte state
// update of the option walk is a single registered step between the input and result registers.
// Stalls: while a result waits on result.ready, bytes that close no area
// keep flowing; a byte that closes an area waits in the input register
// until the result register is free.
// Reset: rst clears both registers and the walk state; no result is pending.
// MAX_AREA sets the byte count past which an area is reported too long.
`timescale 1ns / 1ps
`default_nettype none

module tcp_syn_option_parser_top #(
  parameter int MAX_AREA = 40
) (
  input wire logic    clk,
  input wire logic    rst,
  tsop_in_if.sink     opts,
  tsop_out_if.source  result
);

  tsop_pkg::item_t   in_item;
  tsop_pkg::item_t   held_item;
  tsop_pkg::result_t step_res;
  tsop_pkg::result_t out_data;
  logic held_valid;
  logic take;
  logic res_has;
  logic out_free;

  assign in_item = '{opt_byte: opts.opt_byte, last_byte: opts.last_byte,
                     empty_area: opts.empty_area};

  // A byte is parsed unless its result would find the result register full.
  assign take = held_valid && (!res_has || out_free);

  tsop_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (opts.valid),
    .in_ready   (opts.ready),
    .in_item    (in_item),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  tsop_parse #(
    .MAX_AREA (MAX_AREA)
  ) u_parse (
    .clk     (clk),
    .rst     (rst),
    .step    (take),
    .item    (held_item),
    .res_has (res_has),
    .res     (step_res)
  );

  tsop_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (take && res_has),
    .load_data (step_res),
    .free      (out_free),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (out_data)
  );

  // Result payload onto the channel.
  assign result.status      = out_data.status;
  assign result.mss_found   = out_data.mss_found;
  assign result.seg_size    = out_data.seg_size;
  assign result.scale_found = out_data.scale_found;
  assign result.scale_shift = out_data.scale_shift;
  assign result.sack_ok     = out_data.sack_ok;
  assign result.stamp_found = out_data.stamp_found;
  assign result.stamp_value = out_data.stamp_value;
  assign result.stamp_echo  = out_data.stamp_echo;

endmodule

`default_nettype wire

@@ hdl/tsop_in_reg.sv @@
// Input register stage: holds one option byte request until the parser takes it.
// Depends on tsop_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsop_in_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire tsop_pkg::item_t in_item,
  input  wire logic          take,
  output logic               held_valid,
  output tsop_pkg::item_t    held_item
);

  // The stage can load when empty or when its item leaves this cycle.
  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

`default_nettype wire

@@ hdl/tsop_parse.sv @@
// Option walk state and per-byte update logic; forms the result on the last byte.
// Depends on tsop_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsop_parse #(
  parameter int MAX_AREA = 40
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire tsop_pkg::item_t item,
  output logic                 res_has,
  output tsop_pkg::result_t    res
);

  localparam logic [1:0] PH_KIND = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;
  localparam logic [1:0] PH_STOP = 2'd3;

  localparam int F_MSS   = 0;
  localparam int F_SCALE = 1;
  localparam int F_SACK  = 2;
  localparam int F_STAMP = 3;

  localparam logic [7:0] KIND_END   = 8'd0;
  localparam logic [7:0] KIND_NOP   = 8'd1;
  localparam logic [7:0] KIND_MSS   = 8'd2;
  localparam logic [7:0] KIND_SCALE = 8'd3;
  localparam logic [7:0] KIND_SACK  = 8'd4;
  localparam logic [7:0] KIND_STAMP = 8'd8;

  localparam logic [7:0] SCALE_MAX = 8'd14;
  localparam logic [tsop_pkg::COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [tsop_pkg::COUNT_W-1:0] AREA_LIMIT = tsop_pkg::COUNT_W'(MAX_AREA);

  logic [tsop_pkg::COUNT_W-1:0] area_count, area_count_next;
  logic [1:0]  parse_phase, parse_phase_next;
  logic [7:0]  cur_kind, cur_kind_next;
  logic [7:0]  cur_len, cur_len_next;
  logic [7:0]  left_in_option, left_in_option_next;
  logic [63:0] body_shift, body_shift_next;
  logic [2:0]  latched_status, latched_status_next;
  logic [3:0]  found_flags, found_flags_next;
  logic [15:0] held_mss, held_mss_next;
  logic [3:0]  held_scale, held_scale_next;
  logic [63:0] held_stamps, held_stamps_next;
  logic        finish;
  logic [7:0]  left_dec;
  logic [2:0]  final_status;

  assign res_has  = item.last_byte || item.empty_area;
  assign left_dec = left_in_option - 8'd1;

  // Byte walk: one kind, length or body byte per step.
  always_comb begin
    area_count_next     = (area_count != COUNT_MAX) ? area_count + 1'b1 : area_count;
    parse_phase_next    = parse_phase;
    cur_kind_next       = cur_kind;
    cur_len_next        = cur_len;
    left_in_option_next = left_in_option;
    body_shift_next     = body_shift;
    latched_status_next = latched_status;
    found_flags_next    = found_flags;
    held_mss_next       = held_mss;
    held_scale_next     = held_scale;
    held_stamps_next    = held_stamps;
    finish              = 1'b0;

    case (parse_phase)
      PH_KIND: begin
        if (item.opt_byte == KIND_END) begin
          parse_phase_next = PH_STOP;
        end else if (item.opt_byte != KIND_NOP) begin
          cur_kind_next    = item.opt_byte;
          parse_phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        cur_len_next = item.opt_byte;
        if (item.opt_byte < 8'd2) begin
          latched_status_next = tsop_pkg::ST_BAD_LEN;
          parse_phase_next    = PH_STOP;
        end else begin
          left_in_option_next = item.opt_byte - 8'd2;
          body_shift_next     = '0;
          if (item.opt_byte == 8'd2) begin
            finish = 1'b1;
          end else begin
            parse_phase_next = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        body_shift_next     = {body_shift[55:0], item.opt_byte};
        left_in_option_next = left_dec;
        finish              = (left_dec == 8'd0);
      end
      default: begin
      end
    endcase

    // A complete known option is checked for length, duplicates and a zero MSS; a scale above 14 is clamped.
    if (finish) begin
      parse_phase_next = PH_KIND;
      case (cur_kind)
        KIND_MSS: begin
          if (cur_len_next != 8'd4) begin
            latched_status_next = tsop_pkg::ST_BAD_LEN;
            parse_phase_next    = PH_STOP;
          end else if (found_flags[F_MSS]) begin
            latched_status_next = tsop_pkg::ST_DUP;
            parse_phase_next    = PH_STOP;
          end else if (body_shift_next[15:0] == 16'd0) begin
            latched_status_next = tsop_pkg::ST_BAD_MSS;
            parse_phase_next    = PH_STOP;
          end else begin
            held_mss_next           = body_shift_next[15:0];
            found_flags_next[F_MSS] = 1'b1;
          end
        end
        KIND_SCALE: begin
          if (cur_len_next != 8'd3) begin
            latched_status_next = tsop_pkg::ST_BAD_LEN;
            parse_phase_next    = PH_STOP;
          end else if (found_flags[F_SCALE]) begin
            latched_status_next = tsop_pkg::ST_DUP;
            parse_phase_next    = PH_STOP;
          end else begin
            held_scale_next = (body_shift_next[7:0] > SCALE_MAX) ? SCALE_MAX[3:0]
                                                                 : body_shift_next[3:0];
            found_flags_next[F_SCALE] = 1'b1;
          end
        end
        KIND_SACK: begin
          if (cur_len_next != 8'd2) begin
            latched_status_next = tsop_pkg::ST_BAD_LEN;
            parse_phase_next    = PH_STOP;
          end else if (found_flags[F_SACK]) begin
            latched_status_next = tsop_pkg::ST_DUP;
            parse_phase_next    = PH_STOP;
          end else begin
            found_flags_next[F_SACK] = 1'b1;
          end
        end
        KIND_STAMP: begin
          if (cur_len_next != 8'd10) begin
            latched_status_next = tsop_pkg::ST_BAD_LEN;
            parse_phase_next    = PH_STOP;
          end else if (found_flags[F_STAMP]) begin
            latched_status_next = tsop_pkg::ST_DUP;
            parse_phase_next    = PH_STOP;
          end else begin
            held_stamps_next          = body_shift_next;
            found_flags_next[F_STAMP] = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // An option still open at the area's end is truncated.
  assign final_status = (parse_phase_next == PH_LEN || parse_phase_next == PH_BODY)
                        ? tsop_pkg::ST_TRUNC : latched_status_next;

  // Result fields; an empty area or an overlong area overrides the options.
  always_comb begin
    res = '0;
    if (item.empty_area) begin
      res = '0;
    end else if (area_count_next > AREA_LIMIT) begin
      res.status = tsop_pkg::ST_TOO_LONG;
    end else begin
      res.status      = final_status;
      res.mss_found   = found_flags_next[F_MSS];
      res.seg_size    = held_mss_next;
      res.scale_found = found_flags_next[F_SCALE];
      res.scale_shift = held_scale_next;
      res.sack_ok     = found_flags_next[F_SACK];
      res.stamp_found = found_flags_next[F_STAMP];
      res.stamp_value = held_stamps_next[63:32];
      res.stamp_echo  = held_stamps_next[31:0];
    end
  end

  // State update; a result returns the walk to its starting point.
  always_ff @(posedge clk) begin
    if (rst || (step && res_has)) begin
      area_count     <= '0;
      parse_phase    <= PH_KIND;
      cur_kind       <= '0;
      cur_len        <= '0;
      left_in_option <= '0;
      body_shift     <= '0;
      latched_status <= tsop_pkg::ST_OK;
      found_flags    <= '0;
      held_mss       <= '0;
      held_scale     <= '0;
      held_stamps    <= '0;
    end else if (step) begin
      area_count     <= area_count_next;
      parse_phase    <= parse_phase_next;
      cur_kind       <= cur_kind_next;
      cur_len        <= cur_len_next;
      left_in_option <= left_in_option_next;
      body_shift     <= body_shift_next;
      latched_status <= latched_status_next;
      found_flags    <= found_flags_next;
      held_mss       <= held_mss_next;
      held_scale     <= held_scale_next;
      held_stamps    <= held_stamps_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/tsop_out_reg.sv @@
// Result register: holds one result request until the receiver takes it.
// Depends on tsop_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsop_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire tsop_pkg::result_t load_data,
  output logic                   free,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tsop_pkg::result_t      out_data
);

  // Free when empty or when the held result is taken this cycle.
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      out_data <= load_data;
    end
  end

endmodule

`default_nettype wire

@@ hdl/tsop_checker.sv @@
// Port-level checks for the TCP SYN option parser, bound to the top level.
// Depends on tsop_pkg and tcp_syn_option_parser_top.
`timescale 1ns / 1ps
`default_nettype none

module tsop_port_checks (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  status,
  input wire logic        mss_found,
  input wire logic [15:0] seg_size,
  input wire logic        scale_found,
  input wire logic [3:0]  scale_shift,
  input wire logic        sack_ok,
  input wire logic        stamp_found,
  input wire logic [31:0] stamp_value,
  input wire logic [31:0] stamp_echo
);

  // No result is pending right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result stays valid and keeps its status, segment size and timestamps.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(seg_size)
      && $stable(stamp_value) && $stable(stamp_echo))
    else $error("stalled result changed");

  // Status code and shift stay in their ranges.
  a_ranges: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= tsop_pkg::ST_BAD_MSS && scale_shift <= 4'd14)
    else $error("status or scale shift out of range");

  // An overlong area reports no options.
  a_too_long: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == tsop_pkg::ST_TOO_LONG |-> !mss_found && !scale_found
      && !sack_ok && !stamp_found)
    else $error("options reported on overlong area");

  // Absent options read as zero.
  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mss_found || seg_size == 16'd0) && (scale_found || scale_shift == 4'd0)
      && (stamp_found || (stamp_value == 32'd0 && stamp_echo == 32'd0)))
    else $error("absent option field not zero");

endmodule

bind tcp_syn_option_parser_top tsop_port_checks u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .status      (result.status),
  .mss_found   (result.mss_found),
  .seg_size    (result.seg_size),
  .scale_found (result.scale_found),
  .scale_shift (result.scale_shift),
  .sack_ok     (result.sack_ok),
  .stamp_found (result.stamp_found),
  .stamp_value (result.stamp_value),
  .stamp_echo  (result.stamp_echo)
);

`default_nettype wire
